// ----- design/aho_corasick_automaton_builder_defines.svh -----
// ----------------------------------------------------------------------------
// Aho-Corasick automaton builder: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef AHO_CORASICK_AUTOMATON_BUILDER_DEFINES_SVH
`define AHO_CORASICK_AUTOMATON_BUILDER_DEFINES_SVH

// Same-cycle implication.
`define ACAB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ACAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/acab_pkg.sv -----
// ----------------------------------------------------------------------------
// acab_pkg
// Types, codes and the byte-to-column map of the automaton builder.
// ----------------------------------------------------------------------------
package acab_pkg;

    localparam int MAX_STATES_DEF   = 1024;
    localparam int ALPHABET_COLUMNS = 30;

    localparam logic [4:0] NO_COLUMN = 5'd0;
    localparam logic [4:0] COL_SPACE = 5'd28;
    localparam logic [4:0] COL_APOS  = 5'd29;

    localparam logic [7:0] SPACE_BYTE   = 8'd32;
    localparam logic [7:0] APOS_BYTE    = 8'd39;
    localparam logic [7:0] LOWER_A_BYTE = 8'd97;
    localparam logic [7:0] LOWER_Z_BYTE = 8'd122;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] REPLY_INSERT = 2'd0;
    localparam logic [1:0] REPLY_BUILD  = 2'd1;
    localparam logic [1:0] REPLY_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] symbol_byte;
        logic       last_byte;
        logic [9:0] query_state;
        logic [4:0] query_column;
    } t_in;

    typedef struct packed {
        logic [1:0] reply_kind;
        logic [9:0] end_state;
        logic [9:0] state_total;
        logic [9:0] goto_target;
        logic [9:0] failure_target;
        logic       is_accepting;
        logic       overflowed;
    } t_out;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_INS,
        S_LOOK,
        S_ROOT_RD,
        S_ROOT_CHK,
        S_POP,
        S_POPW,
        S_FR,
        S_EREQ,
        S_ECHK,
        S_WALK,
        S_WCHK,
        S_WF
    } t_state;

    function automatic logic [4:0] column_of(input logic [7:0] b);
        logic [7:0] d;
        d = b - LOWER_A_BYTE + 8'd1;
        if (b == SPACE_BYTE) return COL_SPACE;
        if (b == APOS_BYTE) return COL_APOS;
        if (b >= LOWER_A_BYTE && b <= LOWER_Z_BYTE) return d[4:0];
        return NO_COLUMN;
    endfunction

endpackage

// ----- design/aho_corasick_automaton_builder.sv -----
// ----------------------------------------------------------------------------
// aho_corasick_automaton_builder
// Goto-table and failure-link construction for an Aho-Corasick automaton.
// ----------------------------------------------------------------------------
// After reset the block clears its goto, failure and accept memories, one
// goto entry per cycle; input stays stalled during that pass. An insert
// byte reads the goto memory and writes it only when it makes a new state;
// a byte with no column, or after an overflow, skips the goto memory. A
// lookup reads the goto, failure and accept memories and then reports. A
// build reads the root's row, then for every queued state reads its failure
// link and each column; each child is queued and its failure chain walked
// step by step; one goto read port sets the pace. Results leave through a
// two-entry output buffer, so a new transaction is taken while one waits.
module aho_corasick_automaton_builder #(
    parameter int MAX_STATES = acab_pkg::MAX_STATES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  acab_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output acab_pkg::t_out o_out
);
    import acab_pkg::*;

`include "aho_corasick_automaton_builder_defines.svh"

    logic res_valid;
    t_out res;
    logic r_pend_v;
    t_out r_pend;
    logic r_out_v;
    t_out r_out;
    logic out_free;

    acab_ctrl #(.MAX_STATES(MAX_STATES)) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .i_busy(r_pend_v),
        .o_res_valid(res_valid),
        .o_res(res)
    );

    assign out_free = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else if (out_free) begin
            // advance the held result first
            if (r_pend_v) begin
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
            end else begin
                r_out_v <= res_valid;
            end
        end else if (res_valid) begin
            r_pend_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_pend_v ? r_pend : res;
        end else if (res_valid) begin
            r_pend <= res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    `ACAB_ASSERT_NOW(a_pend_needs_out, r_pend_v, r_out_v, "held result without output")
    `ACAB_ASSERT_NOW(a_res_into_free, res_valid, !r_pend_v, "result while buffer full")
    `ACAB_ASSERT_NOW(a_take_when_free, !o_in_stall, !r_pend_v, "transaction taken while full")
    `ACAB_ASSERT_NEXT(a_pend_drains, r_pend_v && !i_out_stall, !r_pend_v, "held result stuck")

endmodule

// ----- design/acab_ram.sv -----
// ----------------------------------------------------------------------------
// acab_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module acab_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/acab_ctrl.sv -----
// ----------------------------------------------------------------------------
// acab_ctrl
// Sequencer over the goto, failure, accept and queue memories: clear pass,
// insert, breadth-first failure construction and lookup.
// ----------------------------------------------------------------------------
module acab_ctrl #(
    parameter int MAX_STATES = acab_pkg::MAX_STATES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  acab_pkg::t_in  i_in,
    input  logic           i_busy,
    output logic           o_res_valid,
    output acab_pkg::t_out o_res
);
    import acab_pkg::*;

    localparam int SW     = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int GDEPTH = MAX_STATES * ALPHABET_COLUMNS;
    localparam int GW     = $clog2(GDEPTH);

    function automatic logic [GW-1:0] gidx(input logic [SW-1:0] s, input logic [4:0] c);
        return GW'(s) * GW'(ALPHABET_COLUMNS) + GW'(c);
    endfunction

    t_state          r_state, n_state;
    logic [GW-1:0]   r_clr, n_clr;
    logic [SW-1:0]   r_cursor, n_cursor;
    logic [SW-1:0]   r_last, n_last;
    logic            r_ovf, n_ovf;
    logic            r_lastb, n_lastb;
    logic [GW-1:0]   r_gaddr, n_gaddr;
    logic            r_lk_ok, n_lk_ok;
    logic            r_lkc_ok, n_lkc_ok;
    logic [4:0]      r_col, n_col;
    logic [SW:0]     r_head, n_head;
    logic [SW:0]     r_tail, n_tail;
    logic [SW-1:0]   r_node, n_node;
    logic [SW-1:0]   r_fr, n_fr;
    logic [SW-1:0]   r_st, n_st;
    logic [SW-1:0]   r_a, n_a;
    logic [SW:0]     r_guard, n_guard;

    logic            g_we, g_re;
    logic [GW-1:0]   g_waddr, g_raddr;
    logic [SW-1:0]   g_wdata, g_rd;
    logic            f_we, f_re;
    logic [SW-1:0]   f_waddr, f_raddr, f_wdata, f_rd;
    logic            a_we, a_re;
    logic [SW-1:0]   a_waddr, a_raddr;
    logic            a_wdata, a_rd;
    logic            q_we, q_re;
    logic [SW-1:0]   q_waddr, q_raddr, q_wdata, q_rd;

    acab_ram #(.WIDTH(SW), .DEPTH(GDEPTH), .AW(GW)) u_goto (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_re(g_re), .i_raddr(g_raddr), .o_rdata(g_rd)
    );
    acab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES), .AW(SW)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_re(f_re), .i_raddr(f_raddr), .o_rdata(f_rd)
    );
    acab_ram #(.WIDTH(1), .DEPTH(MAX_STATES), .AW(SW)) u_accept (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_re(a_re), .i_raddr(a_raddr), .o_rdata(a_rd)
    );
    acab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES), .AW(SW)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_re(q_re), .i_raddr(q_raddr), .o_rdata(q_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_cursor <= '0;
            r_last   <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cursor <= n_cursor;
            r_last   <= n_last;
            r_ovf    <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lastb  <= n_lastb;
        r_gaddr  <= n_gaddr;
        r_lk_ok  <= n_lk_ok;
        r_lkc_ok <= n_lkc_ok;
        r_col    <= n_col;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_node   <= n_node;
        r_fr     <= n_fr;
        r_st     <= n_st;
        r_a      <= n_a;
        r_guard  <= n_guard;
    end

    always_comb begin
        logic          accept;
        logic [4:0]    col;
        logic          qs_ok;
        logic          col_ok;
        logic          fin;
        logic [SW-1:0] fin_cur;
        logic          fin_ovf;
        logic          next_col;
        logic          tail_ok;

        n_state  = r_state;
        n_clr    = r_clr;
        n_cursor = r_cursor;
        n_last   = r_last;
        n_ovf    = r_ovf;
        n_lastb  = r_lastb;
        n_gaddr  = r_gaddr;
        n_lk_ok  = r_lk_ok;
        n_lkc_ok = r_lkc_ok;
        n_col    = r_col;
        n_head   = r_head;
        n_tail   = r_tail;
        n_node   = r_node;
        n_fr     = r_fr;
        n_st     = r_st;
        n_a      = r_a;
        n_guard  = r_guard;

        g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_re = 1'b0; g_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;
        a_we = 1'b0; a_waddr = '0; a_wdata = 1'b0; a_re = 1'b0; a_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;

        o_res_valid = 1'b0;
        o_res       = '0;

        o_in_stall = !(r_state == S_IDLE && !i_busy);
        accept     = i_in_valid && !o_in_stall;
        col        = column_of(i_in.symbol_byte);
        qs_ok      = 17'(i_in.query_state) < 17'(MAX_STATES);
        col_ok     = i_in.query_column >= 5'd1 && i_in.query_column <= COL_APOS;
        fin        = 1'b0;
        fin_cur    = r_cursor;
        fin_ovf    = r_ovf;
        next_col   = 1'b0;
        tail_ok    = r_tail < (SW+1)'(MAX_STATES);

        unique case (r_state)
            S_CLR: begin
                g_we    = 1'b1;
                g_waddr = r_clr;
                if (r_clr < GW'(MAX_STATES)) begin
                    f_we    = 1'b1;
                    f_waddr = SW'(r_clr);
                    a_we    = 1'b1;
                    a_waddr = SW'(r_clr);
                end
                if (r_clr == GW'(GDEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + GW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in.command)
                        CMD_INSERT: begin
                            n_lastb = i_in.last_byte;
                            if (col != NO_COLUMN && !r_ovf) begin
                                g_re    = 1'b1;
                                g_raddr = gidx(r_cursor, col);
                                n_gaddr = gidx(r_cursor, col);
                                n_state = S_INS;
                            end else if (i_in.last_byte) begin
                                fin = 1'b1;
                            end
                        end
                        CMD_BUILD: begin
                            n_col   = 5'd1;
                            n_head  = '0;
                            n_tail  = '0;
                            n_state = S_ROOT_RD;
                        end
                        CMD_LOOKUP: begin
                            n_lk_ok  = qs_ok;
                            n_lkc_ok = qs_ok && col_ok;
                            f_re     = qs_ok;
                            f_raddr  = SW'(i_in.query_state);
                            a_re     = qs_ok;
                            a_raddr  = SW'(i_in.query_state);
                            g_re     = qs_ok && col_ok;
                            g_raddr  = gidx(SW'(i_in.query_state), i_in.query_column);
                            n_state  = S_LOOK;
                        end
                        default: begin
                            // unknown command: drop the transaction
                        end
                    endcase
                end
            end
            S_INS: begin
                if (g_rd != '0) begin
                    n_cursor = g_rd;
                end else if ({1'b0, r_last} < (SW+1)'(MAX_STATES - 1)) begin
                    n_last   = r_last + SW'(1);
                    n_cursor = r_last + SW'(1);
                    g_we     = 1'b1;
                    g_waddr  = r_gaddr;
                    g_wdata  = r_last + SW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
                fin_cur = n_cursor;
                fin_ovf = n_ovf;
                fin     = r_lastb;
                n_state = S_IDLE;
            end
            S_LOOK: begin
                o_res_valid          = 1'b1;
                o_res.reply_kind     = REPLY_LOOKUP;
                o_res.state_total    = 10'(r_last);
                o_res.goto_target    = r_lkc_ok ? 10'(g_rd) : 10'd0;
                o_res.failure_target = r_lk_ok ? 10'(f_rd) : 10'd0;
                o_res.is_accepting   = r_lk_ok && a_rd;
                n_state              = S_IDLE;
            end
            S_ROOT_RD: begin
                g_re    = 1'b1;
                g_raddr = gidx('0, r_col);
                n_state = S_ROOT_CHK;
            end
            S_ROOT_CHK: begin
                if (g_rd != '0 && tail_ok) begin
                    f_we    = 1'b1;
                    f_waddr = g_rd;
                    f_wdata = '0;
                    q_we    = 1'b1;
                    q_waddr = r_tail[SW-1:0];
                    q_wdata = g_rd;
                    n_tail  = r_tail + (SW+1)'(1);
                end
                if (r_col == COL_APOS) begin
                    n_state = S_POP;
                end else begin
                    n_col   = r_col + 5'd1;
                    n_state = S_ROOT_RD;
                end
            end
            S_POP: begin
                if (r_head < r_tail) begin
                    q_re    = 1'b1;
                    q_raddr = r_head[SW-1:0];
                    n_head  = r_head + (SW+1)'(1);
                    n_state = S_POPW;
                end else begin
                    o_res_valid       = 1'b1;
                    o_res.reply_kind  = REPLY_BUILD;
                    o_res.state_total = 10'(r_last);
                    n_state           = S_IDLE;
                end
            end
            S_POPW: begin
                n_node  = q_rd;
                f_re    = 1'b1;
                f_raddr = q_rd;
                n_state = S_FR;
            end
            S_FR: begin
                n_fr    = f_rd;
                n_col   = 5'd1;
                n_state = S_EREQ;
            end
            S_EREQ: begin
                g_re    = 1'b1;
                g_raddr = gidx(r_node, r_col);
                n_state = S_ECHK;
            end
            S_ECHK: begin
                if (g_rd == '0) begin
                    next_col = 1'b1;
                end else begin
                    if (tail_ok) begin
                        q_we    = 1'b1;
                        q_waddr = r_tail[SW-1:0];
                        q_wdata = g_rd;
                        n_tail  = r_tail + (SW+1)'(1);
                    end
                    n_a     = g_rd;
                    n_st    = r_fr;
                    n_guard = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                g_re    = 1'b1;
                g_raddr = gidx(r_st, r_col);
                n_state = S_WCHK;
            end
            S_WCHK: begin
                // stop at the root, on a hit, or when the guard runs out
                if (r_st == '0 || g_rd != '0 || r_guard >= (SW+1)'(MAX_STATES)) begin
                    f_we     = 1'b1;
                    f_waddr  = r_a;
                    f_wdata  = g_rd;
                    next_col = 1'b1;
                end else begin
                    f_re    = 1'b1;
                    f_raddr = r_st;
                    n_state = S_WF;
                end
            end
            S_WF: begin
                n_st    = f_rd;
                n_guard = r_guard + (SW+1)'(1);
                n_state = S_WALK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (next_col) begin
            if (r_col == COL_APOS) begin
                n_state = S_POP;
            end else begin
                n_col   = r_col + 5'd1;
                n_state = S_EREQ;
            end
        end

        if (fin) begin
            o_res_valid       = 1'b1;
            o_res.reply_kind  = REPLY_INSERT;
            o_res.end_state   = fin_ovf ? 10'd0 : 10'(fin_cur);
            o_res.state_total = 10'(n_last);
            o_res.overflowed  = fin_ovf;
            a_we              = !fin_ovf;
            a_waddr           = fin_cur;
            a_wdata           = 1'b1;
            n_cursor          = '0;
            n_ovf             = 1'b0;
        end
    end

endmodule

// ----- verif/aho_corasick_automaton_builder_checker.sv -----
// ----------------------------------------------------------------------------
// Automaton builder checker
// Watches both channels, keeps its own goto, failure and accept tables, and
// compares every result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module aho_corasick_automaton_builder_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  acab_pkg::t_in  i_in,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  acab_pkg::t_out i_out,
    output int             o_errors,
    output int             o_pending
);
    import acab_pkg::*;

    localparam int N_ST = MAX_STATES_DEF;

    logic [9:0] trie_next [N_ST][ALPHABET_COLUMNS];
    logic [9:0] fail_link [N_ST];
    logic       accepting [N_ST];
    int         top_state;
    int         cursor;
    logic       ran_out;
    t_out       replies_due [$];

    function automatic int col_for_byte(logic [7:0] b);
        if (b == 8'd32) return 28;
        if (b == 8'd39) return 29;
        if (b >= 8'd97 && b <= 8'd122) return int'(b) - 96;
        return 0;
    endfunction

    function automatic int hop(int s, int c);
        if (s >= N_ST || c >= ALPHABET_COLUMNS) return 0;
        return int'(trie_next[s][c]);
    endfunction

    task automatic link_failures();
        int q [N_ST];
        int head, tail, r, a, st, guard;
        head = 0;
        tail = 0;
        for (int c = 1; c < ALPHABET_COLUMNS; c++) begin
            a = hop(0, c);
            if (a != 0 && tail < N_ST) begin
                fail_link[a] = '0;
                q[tail] = a;
                tail++;
            end
        end
        while (head < tail) begin
            r = q[head];
            head++;
            for (int c = 1; c < ALPHABET_COLUMNS; c++) begin
                a = hop(r, c);
                if (a != 0) begin
                    if (tail < N_ST) begin
                        q[tail] = a;
                        tail++;
                    end
                    st = int'(fail_link[r]);
                    guard = 0;
                    while (st != 0 && hop(st, c) == 0 && guard < N_ST) begin
                        st = int'(fail_link[st]);
                        guard++;
                    end
                    fail_link[a] = 10'(hop(st, c));
                end
            end
        end
    endtask

    task automatic absorb(t_in x);
        t_out r;
        int c;
        r = '0;
        r.state_total = top_state[9:0];
        case (x.command)
            CMD_INSERT: begin
                c = col_for_byte(x.symbol_byte);
                if (c != 0 && !ran_out) begin
                    if (trie_next[cursor][c] != 0) begin
                        cursor = int'(trie_next[cursor][c]);
                    end else if (top_state + 1 < N_ST) begin
                        top_state++;
                        trie_next[cursor][c] = top_state[9:0];
                        cursor = top_state;
                    end else begin
                        ran_out = 1'b1;
                    end
                end
                if (x.last_byte) begin
                    r.reply_kind  = REPLY_INSERT;
                    r.state_total = top_state[9:0];
                    if (ran_out) begin
                        r.overflowed = 1'b1;
                    end else begin
                        accepting[cursor] = 1'b1;
                        r.end_state = cursor[9:0];
                    end
                    cursor  = 0;
                    ran_out = 1'b0;
                    replies_due.push_back(r);
                end
            end
            CMD_BUILD: begin
                link_failures();
                r.reply_kind = REPLY_BUILD;
                replies_due.push_back(r);
            end
            CMD_LOOKUP: begin
                r.reply_kind = REPLY_LOOKUP;
                if (x.query_column >= 5'd1 && x.query_column <= COL_APOS)
                    r.goto_target = 10'(hop(x.query_state, x.query_column));
                r.failure_target = fail_link[x.query_state];
                r.is_accepting   = accepting[x.query_state];
                replies_due.push_back(r);
            end
            default: ;
        endcase
    endtask

    initial begin
        for (int s = 0; s < N_ST; s++) begin
            fail_link[s] = '0;
            accepting[s] = 1'b0;
            for (int c = 0; c < ALPHABET_COLUMNS; c++) trie_next[s][c] = '0;
        end
        top_state = 0;
        cursor    = 0;
        ran_out   = 1'b0;
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) absorb(i_in);
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $time, i_out);
                    o_errors <= o_errors + 1;
                end else begin
                    want = replies_due.pop_front();
                    if (want !== i_out) begin
                        $display("%0t: mismatch expected kind=%0d end=%0d total=%0d",
                                 $time, want.reply_kind, want.end_state,
                                 want.state_total,
                                 " goto=%0d fail=%0d acc=%0d ovf=%0d",
                                 want.goto_target, want.failure_target,
                                 want.is_accepting, want.overflowed);
                        $display("%0t:          actual   kind=%0d end=%0d total=%0d",
                                 $time, i_out.reply_kind, i_out.end_state,
                                 i_out.state_total,
                                 " goto=%0d fail=%0d acc=%0d ovf=%0d",
                                 i_out.goto_target, i_out.failure_target,
                                 i_out.is_accepting, i_out.overflowed);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= replies_due.size();
    end

endmodule

// ----- verif/aho_corasick_automaton_builder_tb.sv -----
// ----------------------------------------------------------------------------
// Automaton builder testbench
// Inserts patterns, builds failure links and looks entries up, under several
// idle and stall mixes, ending with a pattern long enough to exhaust states.
// ----------------------------------------------------------------------------
module aho_corasick_automaton_builder_tb;
    import acab_pkg::*;

    localparam int QUIET_LIMIT = 400000;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic  i_clk;
    logic  i_rst_n;
    logic  in_valid;
    logic  in_stall;
    t_in   in_data;
    logic  out_valid;
    logic  out_stall;
    t_out  out_data;
    int    errors;
    int    pending;
    int    idle_pct;
    int    stall_pct;
    int    quiet;
    int    sent;

    aho_corasick_automaton_builder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_data)
    );

    aho_corasick_automaton_builder_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // End the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_in rand_in();
        logic [31:0] v;
        v = $urandom;
        return t_in'(v[$bits(t_in)-1:0]);
    endfunction

    task automatic send(t_in x);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic put_byte(logic [7:0] b, logic last);
        t_in x;
        x = rand_in();
        x.command     = CMD_INSERT;
        x.symbol_byte = b;
        x.last_byte   = last;
        send(x);
    endtask

    task automatic put_word(string w);
        for (int k = 0; k < w.len(); k++) put_byte(w[k], k == w.len() - 1);
    endtask

    task automatic ask(int s, int c);
        t_in x;
        x = rand_in();
        x.command      = CMD_LOOKUP;
        x.query_state  = s[9:0];
        x.query_column = c[4:0];
        send(x);
    endtask

    task automatic link_all();
        t_in x;
        x = rand_in();
        x.command = CMD_BUILD;
        send(x);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 8'd97 + 8'($urandom_range(3));
        if (r < 80) return 8'd97 + 8'($urandom_range(25));
        if (r < 85) return 8'd32;
        if (r < 90) return 8'd39;
        return 8'($urandom);
    endfunction

    task automatic random_item();
        int r, n;
        t_in x;
        r = $urandom_range(99);
        if (r < 55) begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) put_byte(pick_byte(), k == n - 1);
        end else if (r < 57) begin
            link_all();
        end else if (r < 95) begin
            if ($urandom_range(9) < 8) ask($urandom_range(0, 400), $urandom_range(0, 31));
            else ask($urandom_range(0, 1023), $urandom_range(0, 31));
        end else if (r < 97) begin
            // broken pattern: bytes without an end, finished by a later one
            put_byte(pick_byte(), 1'b0);
        end else begin
            x = rand_in();
            x.command = CMD_UNKNOWN;
            send(x);
        end
    endtask

    initial begin
        t_in junk;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        i_rst_n   <= 1'b0;
        quiet     = 0;
        sent      = 0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put_word("he");
        put_word("she");
        put_word("his");
        put_word("hers");
        put_word("a'b c");
        put_byte(8'd0, 1'b0);
        put_byte(8'd255, 1'b0);
        put_byte(8'd65, 1'b0);
        put_byte(8'd96, 1'b0);
        put_byte(8'd123, 1'b0);
        put_byte(8'd124, 1'b0);
        put_byte(8'd125, 1'b1);
        put_word("z");
        link_all();
        ask(0, 8);
        ask(5, 5);
        ask(1023, 31);
        ask(2, 0);
        ask(0, 27);
        ask(0, 29);
        ask(3, 30);
        junk = '1;
        junk.command = CMD_UNKNOWN;
        send(junk);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            for (int k = 0; k < 30; k++) random_item();
            drain();
        end

        // exhaust the state table, then check the cursor returns to the root
        idle_pct  = 18;
        stall_pct = 18;
        while (u_checker.top_state < MAX_STATES_DEF - 1) begin
            put_byte(8'd97 + 8'($urandom_range(25)), 1'b0);
        end
        repeat (3) put_byte(8'd97 + 8'($urandom_range(25)), 1'b0);
        put_byte(8'd97, 1'b1);
        put_word("zzzq'");
        put_word("he");
        link_all();
        for (int k = 0; k < 20; k++) ask($urandom_range(0, 1023), $urandom_range(1, 29));
        ask(1023, 1);
        drain();
        repeat (100) @(posedge i_clk);

        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/acab_pkg.sv
design/acab_ram.sv
design/acab_ctrl.sv
design/aho_corasick_automaton_builder.sv
verif/aho_corasick_automaton_builder_checker.sv
verif/aho_corasick_automaton_builder_tb.sv
